>>> hdl/adm_pkg.sv
package adm_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int FIELD_W           = 16;
   localparam int CFG_W             = 15;
   localparam int CSR_INDEX_W       = 1;
   localparam int STAGES            = 5;

   localparam logic [CFG_W-1:0] DEADBAND_RESET = 15'd328;
   localparam logic [CFG_W-1:0] GAIN_RESET     = 15'd16384;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN     = 1'd1;

endpackage

>>> hdl/arcade_drive_mixer_core.sv
// Arcade drive mixer: squared-input shaping of a forward and a rotation
// command, mixed by quadrant into left and right drive commands (Q2.14).
//
// Input channel req_*: one transaction carries forward speed and rotation
// rate. Result channel rsp_*: one transaction carries left and right drive.
// Both use valid/ready. Configuration: csr_write_enable writes csr_write_data
// into the register at csr_index (0 = deadband, 1 = gain) at the clock edge;
// write only while no transaction is in flight.
//
// Each transaction passes through the stages magnitude and deadband,
// square, gain multiply, clamp and sign, then quadrant mixing into the
// output register. Throughput is one transaction per cycle while the
// receiver does not stall; the two multipliers of each axis shaper set the stage depth.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads deadband 328 and
// gain 16384 (1.0).
module arcade_drive_mixer_core #(
   parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [adm_pkg::FIELD_W-1:0]    req_forward_speed,
   input  logic signed [adm_pkg::FIELD_W-1:0]    req_rotation_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [adm_pkg::FIELD_W-1:0]    rsp_left_drive,
   output logic signed [adm_pkg::FIELD_W-1:0]    rsp_right_drive,
   input  logic                                  csr_write_enable,
   input  logic [adm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [adm_pkg::CFG_W-1:0]             csr_write_data
);

   localparam int AX_W  = FRAC_BITS + 2;
   localparam int FW    = adm_pkg::FIELD_W;
   localparam int MIX_W = (FRAC_BITS + 3 > FW) ? FRAC_BITS + 3 : FW;
   localparam logic signed [AX_W-1:0] ONE = AX_W'(1) <<< FRAC_BITS;

   logic [adm_pkg::CFG_W-1:0] deadband_ff, gain_ff;
   logic [adm_pkg::STAGES-1:0] vld_ff;
   logic                       advance;
   logic signed [AX_W-1:0]     x_s, z_s;
   logic signed [MIX_W-1:0]    xe, ze, ax, az, peak, left_c, right_c;
   logic signed [FW-1:0]       left_ff, right_ff;

   assign advance   = !vld_ff[adm_pkg::STAGES-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[adm_pkg::STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= adm_pkg::DEADBAND_RESET;
         gain_ff     <= adm_pkg::GAIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            adm_pkg::CSR_DEADBAND: deadband_ff <= csr_write_data;
            adm_pkg::CSR_GAIN:     gain_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[adm_pkg::STAGES-2:0], req_valid};
      end
   end

   adm_axis_shaper #(.FRAC_BITS(FRAC_BITS)) u_forward (
      .clock      (clock),
      .advance    (advance),
      .axis_i     (req_forward_speed),
      .deadband_i (deadband_ff),
      .gain_i     (gain_ff),
      .shaped_o   (x_s)
   );

   adm_axis_shaper #(.FRAC_BITS(FRAC_BITS)) u_rotation (
      .clock      (clock),
      .advance    (advance),
      .axis_i     (req_rotation_rate),
      .deadband_i (deadband_ff),
      .gain_i     (gain_ff),
      .shaped_o   (z_s)
   );

   always_comb begin
      xe   = MIX_W'(x_s);
      ze   = MIX_W'(z_s);
      ax   = xe[MIX_W-1] ? -xe : xe;
      az   = ze[MIX_W-1] ? -ze : ze;
      peak = (ax > az) ? ax : az;
      if (xe[MIX_W-1]) begin
         peak = -peak;
      end
      if (xe[MIX_W-1] == ze[MIX_W-1]) begin
         left_c  = peak;
         right_c = xe - ze;
      end else begin
         left_c  = xe + ze;
         right_c = peak;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_c[FW-1:0];
         right_ff <= right_c[FW-1:0];
      end
   end

   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;

   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> vld_ff[0] == $past(req_valid))
      else $error("entry valid bit does not follow accepted transaction");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> vld_ff == $past(vld_ff))
      else $error("valid bits moved during stall");

   a_shaped_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (x_s <= ONE && x_s >= -ONE && z_s <= ONE && z_s >= -ONE))
      else $error("shaped axis beyond full scale");

endmodule

>>> hdl/adm_axis_shaper.sv
module adm_axis_shaper #(
   parameter int FRAC_BITS = adm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [adm_pkg::FIELD_W-1:0] axis_i,
   input  logic [adm_pkg::CFG_W-1:0]          deadband_i,
   input  logic [adm_pkg::CFG_W-1:0]          gain_i,
   output logic signed [FRAC_BITS+1:0]        shaped_o
);

   localparam int SQ_W   = 2 * adm_pkg::FIELD_W - 1 - FRAC_BITS;
   localparam int PROD_W = adm_pkg::CFG_W + SQ_W;
   localparam int AX_W   = FRAC_BITS + 2;
   localparam int FW     = adm_pkg::FIELD_W;
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   logic [FW-1:0]     abs_c;
   logic [FW-1:0]     mag_in, mag_ff;
   logic [2*FW-1:0]   sq_full;
   logic [SQ_W-1:0]   sq_in, sq_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic [63:0]       scaled;
   logic [AX_W-1:0]   sat_mag;
   logic signed [AX_W-1:0] shaped_in, shaped_ff;
   logic [2:0]        neg_ff;

   // stage 1: magnitude and deadband
   always_comb begin
      abs_c  = axis_i[FW-1] ? (~axis_i + FW'(1)) : axis_i;
      mag_in = ({1'b0, abs_c} < (FW+1)'(deadband_i)) ? '0 : abs_c;
   end

   // stage 2: square
   always_comb begin
      sq_full = (2*FW)'(mag_ff) * (2*FW)'(mag_ff);
      sq_in   = SQ_W'(sq_full >> FRAC_BITS);
   end

   // stage 3: gain
   assign prod_in = PROD_W'(gain_i) * PROD_W'(sq_ff);

   // stage 4: scale, clamp, sign
   always_comb begin
      scaled    = 64'(prod_ff) >> FRAC_BITS;
      sat_mag   = (scaled > ONE) ? AX_W'(ONE) : AX_W'(scaled);
      shaped_in = neg_ff[2] ? -$signed(sat_mag) : $signed(sat_mag);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff    <= mag_in;
         sq_ff     <= sq_in;
         prod_ff   <= prod_in;
         shaped_ff <= shaped_in;
         neg_ff    <= {neg_ff[1:0], axis_i[FW-1]};
      end
   end

   assign shaped_o = shaped_ff;

endmodule

>>> verif/arcade_drive_mixer_core_tb.sv
`timescale 1ns / 100ps

module arcade_drive_mixer_core_tb;

   localparam int FRAC       = adm_pkg::FRAC_BITS_DEFAULT;
   localparam longint ONE_FX = longint'(1) << FRAC;
   localparam int IDLE_LIMIT = 1000;
   localparam int LONG_HOLD  = 120;

   typedef struct packed {
      logic signed [adm_pkg::FIELD_W-1:0] forward_speed;
      logic signed [adm_pkg::FIELD_W-1:0] rotation_rate;
   } drive_command_type;

   typedef struct packed {
      logic signed [adm_pkg::FIELD_W-1:0] left_drive;
      logic signed [adm_pkg::FIELD_W-1:0] right_drive;
   } drive_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [adm_pkg::FIELD_W-1:0] req_forward_speed = '0;
   logic signed [adm_pkg::FIELD_W-1:0] req_rotation_rate = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [adm_pkg::FIELD_W-1:0] rsp_left_drive;
   logic signed [adm_pkg::FIELD_W-1:0] rsp_right_drive;
   logic                               csr_write_enable = 1'b0;
   logic [adm_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [adm_pkg::CFG_W-1:0]          csr_write_data = '0;

   logic [adm_pkg::CFG_W-1:0] deadband_q = adm_pkg::DEADBAND_RESET;
   logic [adm_pkg::CFG_W-1:0] gain_q     = adm_pkg::GAIN_RESET;

   drive_command_type pending_commands[$];
   drive_pair_type    expected_drive[$];

   int mismatches   = 0;
   int idle_cycles  = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int send_wait    = 0;
   int recv_wait    = 0;
   int hold_left    = 0;

   arcade_drive_mixer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_forward_speed (req_forward_speed),
      .req_rotation_rate (req_rotation_rate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint shape_command(logic signed [adm_pkg::FIELD_W-1:0] v);
      bit     neg;
      longint m;
      longint sq;
      longint mag;
      neg = (v < 0);
      m   = neg ? -longint'(v) : longint'(v);
      if (m < longint'(deadband_q)) return 0;
      sq  = (m * m) >>> FRAC;
      mag = (longint'(gain_q) * sq) >>> FRAC;
      if (mag > ONE_FX) mag = ONE_FX;
      return neg ? -mag : mag;
   endfunction

   function automatic drive_pair_type mix_drive(drive_command_type cmd);
      longint         x;
      longint         z;
      longint         ax;
      longint         az;
      longint         peak;
      longint         l;
      longint         r;
      drive_pair_type res;
      x    = shape_command(cmd.forward_speed);
      z    = shape_command(cmd.rotation_rate);
      ax   = (x < 0) ? -x : x;
      az   = (z < 0) ? -z : z;
      peak = (ax > az) ? ax : az;
      if (x < 0) peak = -peak;
      if ((x >= 0) == (z >= 0)) begin
         l = peak;
         r = x - z;
      end else begin
         l = x + z;
         r = peak;
      end
      res.left_drive  = l[adm_pkg::FIELD_W-1:0];
      res.right_drive = r[adm_pkg::FIELD_W-1:0];
      return res;
   endfunction

   function automatic logic signed [adm_pkg::FIELD_W-1:0] random_axis();
      int t;
      case ($urandom_range(0, 9))
         0, 1, 2: t = int'($urandom);
         3, 4, 5: t = int'($urandom_range(0, 32768)) - 16384;
         6: begin
            t = int'(deadband_q) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) t = -t;
         end
         7: begin
            case ($urandom_range(0, 5))
               0: t = 16384;
               1: t = -16384;
               2: t = 32767;
               3: t = -32768;
               4: t = 0;
               default: t = -1;
            endcase
         end
         8: t = int'($urandom_range(0, 600)) - 300;
         default: t = ($urandom_range(0, 1) ? 16384 : -16384) + int'($urandom_range(0, 40)) - 20;
      endcase
      return t[adm_pkg::FIELD_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         bit holding;
         holding = req_valid;
         if (req_valid && req_ready) begin
            expected_drive.push_back(mix_drive({req_forward_speed, req_rotation_rate}));
            items_sent++;
            send_wait = ((items_sent / 150) % 3 == 0) ? 0 : int'($urandom_range(0, 7));
            holding = 1'b0;
         end
         if (!holding) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_commands.size() > 0) begin
               drive_command_type cmd;
               cmd = pending_commands.pop_front();
               req_valid         <= 1'b1;
               req_forward_speed <= cmd.forward_speed;
               req_rotation_rate <= cmd.rotation_rate;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: left %0d right %0d",
                           rsp_left_drive, rsp_right_drive);
            end else begin
               drive_pair_type exp_pair;
               exp_pair = expected_drive.pop_front();
               if (rsp_left_drive !== exp_pair.left_drive ||
                   rsp_right_drive !== exp_pair.right_drive) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                              exp_pair.left_drive, rsp_left_drive,
                              exp_pair.right_drive, rsp_right_drive);
               end
            end
            results_seen++;
            if (results_seen % 600 == 300) hold_left = LONG_HOLD;
            recv_wait = ((results_seen / 128) % 4 == 1) ? 0 : int'($urandom_range(0, 7));
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic write_register(logic [adm_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [adm_pkg::CFG_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      if (idx == adm_pkg::CSR_DEADBAND) deadband_q = val;
      else if (idx == adm_pkg::CSR_GAIN) gain_q = val;
   endtask

   task automatic queue_random(int count);
      drive_command_type cmd;
      repeat (count) begin
         cmd.forward_speed = random_axis();
         cmd.rotation_rate = random_axis();
         pending_commands.push_back(cmd);
      end
   endtask

   task automatic drain_pipeline();
      while (pending_commands.size() != 0 || req_valid || expected_drive.size() != 0)
         @(negedge clock);
      repeat (adm_pkg::STAGES + 2) @(posedge clock);
   endtask

   task automatic run_setting(logic [adm_pkg::CFG_W-1:0] db, logic [adm_pkg::CFG_W-1:0] gn,
                              int count);
      write_register(adm_pkg::CSR_DEADBAND, db);
      write_register(adm_pkg::CSR_GAIN, gn);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      queue_random(count);
      drain_pipeline();
   endtask

   task automatic queue_command(int fwd, int rot);
      drive_command_type cmd;
      cmd.forward_speed = fwd[adm_pkg::FIELD_W-1:0];
      cmd.rotation_rate = rot[adm_pkg::FIELD_W-1:0];
      pending_commands.push_back(cmd);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_command(0, 0);
      queue_command(16384, 0);
      queue_command(-16384, 0);
      queue_command(0, 16384);
      queue_command(0, -16384);
      queue_command(16384, 16384);
      queue_command(16384, -16384);
      queue_command(-16384, 16384);
      queue_command(-16384, -16384);
      queue_command(32767, -32768);
      queue_command(-32768, 32767);
      queue_command(-32768, -32768);
      queue_command(32767, 32767);
      queue_command(327, 327);
      queue_command(328, -328);
      queue_command(-327, 329);
      queue_command(8192, -4096);
      queue_command(-8192, 12000);
      queue_command(100, -20000);
      queue_command(-12000, -9000);
      queue_random(250);
      drain_pipeline();
      run_setting(15'd0, 15'd32767, 240);
      run_setting(15'd16384, 15'd0, 200);
      run_setting(15'd32767, 15'd16384, 200);
      run_setting(15'd0, 15'd16384, 240);
      run_setting(15'd16384, 15'd32767, 200);
      repeat (3) begin
         run_setting(15'($urandom_range(0, 2000)), 15'($urandom_range(0, 32767)), 220);
      end
      if (mismatches == 0 && expected_drive.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/adm_pkg.sv
hdl/adm_axis_shaper.sv
hdl/arcade_drive_mixer_core.sv
verif/arcade_drive_mixer_core_tb.sv
